/* rtl/nacd_pkg.sv */
// Shared types, constants and helper functions for the nixie digit former.
`default_nettype none

package nacd_pkg;

  // Tube count and length of the anti-poisoning digit order
  localparam int NumTubes    = 6;
  localparam int OrderLength = 10;

  // Configuration register indexes
  localparam logic CfgTwelveHour = 1'b0;
  localparam logic CfgCycleDelay = 1'b1;

  // Reset value of the cycle delay in milliseconds
  localparam logic [15:0] CycleDelayReset = 16'd150;

  typedef logic [3:0] digit_t;
  typedef digit_t [NumTubes-1:0] tube_digits_t;
  typedef logic [NumTubes-1:0] tube_mask_t;

  // Fixed anti-poisoning order
  localparam digit_t DigitOrder [10] = '{
    4'd1, 4'd0, 4'd2, 4'd9, 4'd8, 4'd3, 4'd4, 4'd7, 4'd6, 4'd5
  };

  // Tens of a 6-bit value (0..63), by compare chain
  function automatic logic [2:0] dec_tens(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  // Units of a 6-bit value: v - 10 * tens
  function automatic digit_t dec_units(input logic [5:0] v);
    logic [2:0] t;
    logic [5:0] tx10;
    logic [5:0] u;
    t    = dec_tens(v);
    tx10 = {t, 3'b000} - {3'b000, t} - {3'b000, t} + {2'b00, t, 1'b0} + {2'b00, t, 1'b0};
    u    = v - tx10;
    return u[3:0];
  endfunction

  // Entry of the digit order; positions past the end read the last entry
  function automatic digit_t order_entry(input logic [3:0] pos);
    logic [3:0] p;
    if (pos >= 4'(OrderLength)) p = 4'(OrderLength - 1);
    else                        p = pos;
    return DigitOrder[p];
  endfunction

endpackage

`default_nettype wire

/* rtl/nacd_digits.sv */
// Splits the time of day into six tube digits, in 12- or 24-hour form.
`default_nettype none

module nacd_digits (
  input  wire logic                  twelve_hour,
  input  wire logic [4:0]            hours,
  input  wire logic [5:0]            minutes,
  input  wire logic [5:0]            seconds,
  output nacd_pkg::tube_digits_t     digits
);

  logic [4:0] hours_adj;

  // 12-hour form: hours above 12 lose 12, hour 0 shows 12
  always_comb begin
    hours_adj = hours;
    if (twelve_hour) begin
      if (hours > 5'd12) hours_adj = hours - 5'd12;
      if (hours_adj == 5'd0) hours_adj = 5'd12;
    end
  end

  // Tens first: hours, minutes, seconds
  always_comb begin
    digits    = '0;
    digits[0] = {1'b0, nacd_pkg::dec_tens({1'b0, hours_adj})};
    digits[1] = nacd_pkg::dec_units({1'b0, hours_adj});
    digits[2] = {1'b0, nacd_pkg::dec_tens(minutes)};
    digits[3] = nacd_pkg::dec_units(minutes);
    digits[4] = {1'b0, nacd_pkg::dec_tens(seconds)};
    digits[5] = nacd_pkg::dec_units(seconds);
  end

endmodule

`default_nettype wire

/* rtl/nixie_antipoison_clock_digits_core.sv */
// Nixie clock digit former with cathode anti-poisoning cycle (top level).
//
// Input stream: one beat per display refresh carrying hours, minutes,
// seconds and a free-running millisecond timestamp. Output stream: one
// beat per input beat with six tube digits, the separator dots and a
// flag that is high while an anti-poisoning cycle runs.
// Configuration: cfg_we writes cfg_data to register cfg_index (0: 12-hour
// mode, 1: cycle delay in ms); write only while no beat is in flight.
// Data path: an accepted beat is captured in the input register, passes
// through the digit and cycle logic and is registered in the output
// register before it appears on out_*. Throughput: one beat per cycle
// while out_tready allows; the input register, the digit and cycle logic,
// and the output register form a single-pass pipeline, and the cycle state
// updates in the same cycle so the next beat sees it.
// Stall: when out_tready is low the result holds in the output register
// and the input register holds one more beat; in_tready then drops.
// Reset (rst_n low, synchronous): both stages empty, no cycle running,
// 24-hour mode, cycle delay 150 ms.
`default_nettype none

module nixie_antipoison_clock_digits_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // hours[4:0], minutes[10:5], seconds[16:11],
                                       // now_ms[48:17], zero pad [55:49]
  // Output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // tube_digit_0..5 [23:0] (4 bits each),
                                       // dots_on[24], cycling[25], zero pad [31:26]
);

  localparam int NumTubes = nacd_pkg::NumTubes;

  // Configuration registers
  logic        twelve_r;
  logic [15:0] delay_r;

  // Input stage
  logic        in_valid_r;
  logic [4:0]  hours_r;
  logic [5:0]  minutes_r;
  logic [5:0]  seconds_r;
  logic [31:0] now_r;

  // Cycle state
  logic                 active_r, active_nxt;
  logic                 phase_r, phase_nxt;
  logic [3:0]           pos_r, pos_nxt;
  logic [31:0]          last_r, last_nxt;
  nacd_pkg::tube_mask_t settled_r, settled_nxt;

  // Output stage
  logic        out_valid_r;
  logic [31:0] out_data_r, out_data_nxt;

  logic                  advance;
  nacd_pkg::tube_digits_t digits;
  nacd_pkg::tube_digits_t shown;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twelve_r <= 1'b0;
      delay_r  <= nacd_pkg::CycleDelayReset;
    end else if (cfg_we) begin
      case (cfg_index)
        nacd_pkg::CfgTwelveHour: twelve_r <= cfg_data[0];
        nacd_pkg::CfgCycleDelay: delay_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hours_r   <= in_tdata[4:0];
      minutes_r <= in_tdata[10:5];
      seconds_r <= in_tdata[16:11];
      now_r     <= in_tdata[48:17];
    end
  end

  nacd_digits u_digits (
    .twelve_hour (twelve_r),
    .hours       (hours_r),
    .minutes     (minutes_r),
    .seconds     (seconds_r),
    .digits      (digits)
  );

  // Cycle start, step timing and per-tube settling
  always_comb begin
    logic                 start;
    logic                 act0;
    logic                 phase0;
    logic [3:0]           pos0;
    logic [31:0]          last0;
    nacd_pkg::tube_mask_t settled0;
    logic [31:0]          elapsed;
    logic                 due;
    nacd_pkg::digit_t     entry;

    start    = !active_r && (seconds_r == 6'd0);
    act0     = active_r || start;
    phase0   = start ? 1'b0 : phase_r;
    pos0     = start ? 4'd0 : pos_r;
    last0    = start ? now_r : last_r;
    settled0 = start ? '0 : settled_r;

    elapsed  = now_r - last0;
    due      = elapsed > {16'd0, delay_r};

    active_nxt  = act0;
    phase_nxt   = phase0;
    pos_nxt     = pos0;
    last_nxt    = last0;
    settled_nxt = settled0;
    shown       = digits;
    entry       = nacd_pkg::order_entry(pos0);

    if (act0) begin
      if (!phase0) begin
        // Phase one: whole display shows the current entry
        for (int i = 0; i < NumTubes; i++) shown[i] = entry;
        if (due) begin
          last_nxt = now_r;
          pos_nxt  = pos0 + 4'd1;
          if (pos_nxt >= 4'(nacd_pkg::OrderLength - 1)) phase_nxt = 1'b1;
        end
      end else begin
        // Phase two: walk back, tubes stop on their own digit
        if (due) begin
          last_nxt = now_r;
          if (pos0 != 4'd0) pos_nxt = pos0 - 4'd1;
          if (pos_nxt == 4'd0) active_nxt = 1'b0;
        end
        entry = nacd_pkg::order_entry(pos_nxt);
        for (int i = 0; i < NumTubes; i++) begin
          if (!settled0[i]) begin
            if (digits[i] == entry) settled_nxt[i] = 1'b1;
            else                    shown[i]       = entry;
          end
        end
      end
    end

    out_data_nxt        = '0;
    out_data_nxt[23:0]  = shown;
    out_data_nxt[24]    = seconds_r[0];
    out_data_nxt[25]    = active_nxt;
  end

  // Cycle state update, once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      phase_r   <= 1'b0;
      pos_r     <= 4'd0;
      last_r    <= 32'd0;
      settled_r <= '0;
    end else if (advance) begin
      active_r  <= active_nxt;
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      last_r    <= last_nxt;
      settled_r <= settled_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Position never leaves the digit order
  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 4'(nacd_pkg::OrderLength - 1))
    else $error("order position past end of order");

  // Tubes only settle during the walk back
  assert property (@(posedge clk) disable iff (!rst_n)
    (settled_r != '0) |-> phase_r)
    else $error("settled tubes outside phase two");

  // A beat with seconds zero and no cycle running starts a cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !active_r && seconds_r == 6'd0) |=> (active_r && out_tdata[25]))
    else $error("cycle did not start on seconds zero");

  // Every processed beat leaves a result waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed beat lost");

endmodule

`default_nettype wire
